@@ rtl/core/triangle_depth_test_defines.svh @@
// Assertion helpers for the RTL (used by tdt_ctrl); clk and arst_n come from the using module.
`ifndef TRIANGLE_DEPTH_TEST_DEFINES_SVH
`define TRIANGLE_DEPTH_TEST_DEFINES_SVH

// Same-cycle implication.
`define TDT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TDT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/tdt_pkg.sv @@
`timescale 1ns / 1ps

package tdt_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int DEPTH_BITS_DEF = 32;

	localparam int CFG_BITS       = 9;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_HEIGHT = 1'b1;
	localparam logic [CFG_BITS-1:0]       ACTIVE_RESET      = 9'd256;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_TEST  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] SLOT_NONE = 2'd3;

	localparam logic [2:0] ST_PASS    = 3'd0;
	localparam logic [2:0] ST_HIDDEN  = 3'd1;
	localparam logic [2:0] ST_OUTSIDE = 3'd2;
	localparam logic [2:0] ST_DEGEN   = 3'd3;
	localparam logic [2:0] ST_DONE    = 3'd4;

	// Saturated corner reciprocal depth (distance zero or one).
	localparam logic [31:0] INV_INFINITY = 32'hFFFF_FFFF;

	localparam int DIV_BITS = 64;
	localparam logic [63:0] WEIGHT_LIMIT = 64'd1 << 29;

	// Edge/corner index: 0 is the area edge, 1..3 the pixel edges.
	localparam logic [1:0] K_AREA  = 2'd0;
	localparam logic [1:0] K_FIRST = 2'd1;
	localparam logic [1:0] K_LAST  = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [1:0]  vertex_slot;
		logic [15:0] vertex_x;
		logic [15:0] vertex_y;
		logic [31:0] vertex_depth;
		logic [7:0]  pixel_x;
		logic [7:0]  pixel_y;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] depth_value;
	} out_item_t;

	typedef enum logic [4:0] {
		C_SWEEP,
		C_IDLE,
		C_DECODE,
		C_LOAD_DIV,
		C_LOAD_WAIT,
		C_EDGE_MUL,
		C_EDGE_SUB,
		C_AREA_CHK,
		C_W_DIV,
		C_W_WAIT,
		C_W_REG,
		C_W_MUL,
		C_W_ACC,
		C_R_DIV,
		C_R_WAIT,
		C_R_REG,
		C_READ,
		C_RESULT
	} ctrl_state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_SWEEP,
		DP_CAPTURE,
		DP_DIV_LOAD,
		DP_EDGE_MUL,
		DP_EDGE_SUB,
		DP_DIV_WEIGHT,
		DP_WEIGHT,
		DP_WEIGHT_MUL,
		DP_ACC,
		DP_DIV_RECIP,
		DP_DEPTH,
		DP_READ,
		DP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] k;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       outside;
		logic       area_zero;
		logic       div_done;
		logic       sweep_last;
	} dp_stat_t;

endpackage

@@ rtl/core/tdt_div.sv @@
`timescale 1ns / 1ps

module tdt_div import tdt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_BITS-1:0] dividend,
	input  logic [DIV_BITS-1:0] divisor,
	output logic                done,
	output logic [DIV_BITS-1:0] quotient
);

	localparam int CNT_BITS = $clog2(DIV_BITS + 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DIV_BITS-1:0] rem_q;
	logic [DIV_BITS-1:0] nq_q;
	logic [DIV_BITS-1:0] den_q;
	logic [DIV_BITS:0]   trial;
	logic [DIV_BITS:0]   diff;
	logic                take;

	assign trial = {rem_q, nq_q[DIV_BITS-1]};
	assign diff  = trial - {1'b0, den_q};
	assign take  = !diff[DIV_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_BITS'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(DIV_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nq_q  <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
			nq_q  <= {nq_q[DIV_BITS-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = nq_q;

endmodule

@@ rtl/core/tdt_dpath.sv @@
`timescale 1ns / 1ps

module tdt_dpath import tdt_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctrl_cmd_t                 cmd,
	output dp_stat_t                  stat,
	input  in_item_t                  item,
	output out_item_t                 result,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]       cfg_data
);

	localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(STORE_SIZE);
	localparam logic [CFG_BITS-1:0] W_CAP = CFG_BITS'((MAX_WIDTH > 511) ? 511 : MAX_WIDTH);
	localparam logic [CFG_BITS-1:0] H_CAP = CFG_BITS'((MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT);
	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
	localparam logic [63:0] DEPTH_MAX64 = 64'(DEPTH_MAX);

	logic [CFG_BITS-1:0] width_q;
	logic [CFG_BITS-1:0] height_q;
	logic [CFG_BITS-1:0] w_eff;
	logic [CFG_BITS-1:0] h_eff;

	in_item_t          item_q;
	logic              outside_q;
	logic [AW-1:0]     idx_q;
	logic [16:0]       row_off;
	logic [AW-1:0]     sweep_q;

	logic [15:0]       cx_q [3];
	logic [15:0]       cy_q [3];
	logic [31:0]       cinv_q [3];

	logic [15:0]       ax, ay, bx, by, tx, ty;
	logic signed [16:0] dx1, dy1, dx2, dy2;
	logic signed [33:0] prod_a_q, prod_b_q;
	logic signed [34:0] edge_q [4];

	logic signed [34:0] edge_k;
	logic [34:0]       mag_e, mag_a;
	logic              neg_q;
	logic [63:0]       qsat;
	logic [30:0]       mag_w;
	logic signed [30:0] weight_q;
	logic signed [32:0] cinv_sel;
	logic signed [63:0] wprod_q;
	logic signed [63:0] acc_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic [DEPTH_BITS-1:0] rd_q;

	logic              div_start;
	logic [63:0]       div_num, div_den, recip_den, quot;
	logic              div_done;

	logic [DEPTH_BITS-1:0] store_mem [STORE_SIZE];
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [DEPTH_BITS-1:0] mem_wdata;
	logic              emit, area_zero, closer;
	out_item_t         result_q;

	assign w_eff = (width_q > W_CAP) ? W_CAP : width_q;
	assign h_eff = (height_q > H_CAP) ? H_CAP : height_q;
	assign row_off = item.pixel_y * w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ACTIVE_RESET;
			height_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_WIDTH:  width_q  <= cfg_data;
				REG_ACTIVE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign emit = (cmd.op == DP_EMIT);
	assign area_zero = (edge_q[K_AREA] == '0);
	assign closer = (depth_q < rd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			for (int i = 0; i < 3; i++) begin
				cx_q[i]   <= '0;
				cy_q[i]   <= '0;
				cinv_q[i] <= '0;
			end
		end else begin
			if (cmd.op == DP_SWEEP)
				sweep_q <= sweep_q + AW'(1);
			if (emit && item_q.operation == OP_LOAD && item_q.vertex_slot != SLOT_NONE) begin
				cx_q[item_q.vertex_slot]   <= item_q.vertex_x;
				cy_q[item_q.vertex_slot]   <= item_q.vertex_y;
				cinv_q[item_q.vertex_slot] <= (quot > 64'(INV_INFINITY)) ? INV_INFINITY
					: quot[31:0];
			end
		end
	end

	// Edge operand selection.
	assign tx = {item_q.pixel_x, 8'd0};
	assign ty = {item_q.pixel_y, 8'd0};

	always_comb begin
		ax = cx_q[0]; ay = cy_q[0];
		bx = cx_q[1]; by = cy_q[1];
		case (cmd.k)
			2'd0: begin
				ax = cx_q[0]; ay = cy_q[0]; bx = cx_q[1]; by = cy_q[1];
			end
			2'd1: begin
				ax = cx_q[1]; ay = cy_q[1]; bx = cx_q[2]; by = cy_q[2];
			end
			2'd2: begin
				ax = cx_q[2]; ay = cy_q[2]; bx = cx_q[0]; by = cy_q[0];
			end
			default: begin
				ax = cx_q[0]; ay = cy_q[0]; bx = cx_q[1]; by = cy_q[1];
			end
		endcase
	end

	assign dx1 = {1'b0, bx} - {1'b0, ax};
	assign dy1 = {1'b0, by} - {1'b0, ay};
	assign dx2 = (cmd.k == K_AREA) ? ({1'b0, cx_q[2]} - {1'b0, ax}) : ({1'b0, tx} - {1'b0, ax});
	assign dy2 = (cmd.k == K_AREA) ? ({1'b0, cy_q[2]} - {1'b0, ay}) : ({1'b0, ty} - {1'b0, ay});

	// Divider operands.
	assign edge_k   = edge_q[cmd.k];
	assign mag_e    = edge_k[34] ? 35'(-edge_k) : 35'(edge_k);
	assign mag_a    = edge_q[K_AREA][34] ? 35'(-edge_q[K_AREA]) : 35'(edge_q[K_AREA]);
	assign recip_den = (!acc_q[63] && acc_q != '0) ? 64'(acc_q) : 64'd1;

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = 64'd1;
		case (cmd.op)
			DP_DIV_LOAD: begin
				div_start = 1'b1;
				div_num   = (64'd1 << 32) + {33'd0, item_q.vertex_depth[31:1]};
				div_den   = (item_q.vertex_depth <= 32'd1) ? 64'd1 : {32'd0, item_q.vertex_depth};
			end
			DP_DIV_WEIGHT: begin
				div_start = 1'b1;
				div_num   = {13'd0, mag_e, 16'd0} + {30'd0, mag_a[34:1]};
				div_den   = {29'd0, mag_a};
			end
			DP_DIV_RECIP: begin
				div_start = 1'b1;
				div_num   = (64'd1 << 48) + {1'b0, recip_den[63:1]};
				div_den   = recip_den;
			end
			default: ;
		endcase
	end

	tdt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (quot)
	);

	assign qsat     = (quot > WEIGHT_LIMIT) ? WEIGHT_LIMIT : quot;
	assign mag_w    = {1'b0, qsat[29:0]};
	assign cinv_sel = $signed({1'b0, cinv_q[cmd.k - K_FIRST]});

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_CAPTURE: begin
				item_q    <= item;
				outside_q <= ({1'b0, item.pixel_x} >= w_eff) || ({1'b0, item.pixel_y} >= h_eff);
				idx_q     <= AW'(row_off + {9'd0, item.pixel_x});
				acc_q     <= '0;
			end
			DP_EDGE_MUL: begin
				prod_a_q <= dx1 * dy2;
				prod_b_q <= dy1 * dx2;
			end
			DP_EDGE_SUB: edge_q[cmd.k] <= 35'(prod_a_q) - 35'(prod_b_q);
			DP_DIV_WEIGHT: neg_q <= edge_k[34] ^ edge_q[K_AREA][34];
			DP_WEIGHT: weight_q <= neg_q ? $signed(-mag_w) : $signed(mag_w);
			DP_WEIGHT_MUL: wprod_q <= 64'(weight_q) * 64'(cinv_sel);
			DP_ACC: acc_q <= acc_q + wprod_q;
			DP_DEPTH: depth_q <= (quot > DEPTH_MAX64) ? DEPTH_MAX : quot[DEPTH_BITS-1:0];
			default: ;
		endcase
	end

	// Depth store: one write port, one registered read port.
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = idx_q;
		mem_wdata = DEPTH_MAX;
		if (cmd.op == DP_SWEEP) begin
			mem_we   = 1'b1;
			mem_addr = sweep_q;
		end else if (emit && !outside_q) begin
			if (item_q.operation == OP_CLEAR)
				mem_we = 1'b1;
			else if (item_q.operation == OP_TEST && !area_zero && closer) begin
				mem_we    = 1'b1;
				mem_wdata = depth_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			store_mem[mem_addr] <= mem_wdata;
		if (cmd.op == DP_READ)
			rd_q <= store_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.status      <= ST_DONE;
			result_q.depth_value <= '0;
			case (item_q.operation)
				OP_TEST: begin
					if (outside_q)
						result_q.status <= ST_OUTSIDE;
					else if (area_zero)
						result_q.status <= ST_DEGEN;
					else begin
						result_q.status      <= closer ? ST_PASS : ST_HIDDEN;
						result_q.depth_value <= 32'(depth_q);
					end
				end
				OP_CLEAR: if (outside_q) result_q.status <= ST_OUTSIDE;
				default: ;
			endcase
		end
	end

	assign result = result_q;

	assign stat.op         = item_q.operation;
	assign stat.outside    = outside_q;
	assign stat.area_zero  = area_zero;
	assign stat.div_done   = div_done;
	assign stat.sweep_last = (sweep_q == AW'(STORE_SIZE - 1));

endmodule

@@ rtl/core/tdt_ctrl.sv @@
`timescale 1ns / 1ps

`include "triangle_depth_test_defines.svh"

module tdt_ctrl import tdt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	output logic      result_valid,
	input  logic      result_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic [1:0]  k_q;
	logic        out_valid_q;
	logic        emit;

	assign emit = (state_q == C_RESULT) && (!out_valid_q || result_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			C_SWEEP:     if (stat.sweep_last) state_d = C_IDLE;
			C_IDLE:      if (item_valid) state_d = C_DECODE;
			C_DECODE: begin
				case (stat.op)
					OP_LOAD: state_d = C_LOAD_DIV;
					OP_TEST: state_d = stat.outside ? C_RESULT : C_EDGE_MUL;
					default: state_d = C_RESULT;
				endcase
			end
			C_LOAD_DIV:  state_d = C_LOAD_WAIT;
			C_LOAD_WAIT: if (stat.div_done) state_d = C_RESULT;
			C_EDGE_MUL:  state_d = C_EDGE_SUB;
			C_EDGE_SUB:  state_d = (k_q == K_LAST) ? C_AREA_CHK : C_EDGE_MUL;
			C_AREA_CHK:  state_d = stat.area_zero ? C_RESULT : C_W_DIV;
			C_W_DIV:     state_d = C_W_WAIT;
			C_W_WAIT:    if (stat.div_done) state_d = C_W_REG;
			C_W_REG:     state_d = C_W_MUL;
			C_W_MUL:     state_d = C_W_ACC;
			C_W_ACC:     state_d = (k_q == K_LAST) ? C_R_DIV : C_W_DIV;
			C_R_DIV:     state_d = C_R_WAIT;
			C_R_WAIT:    if (stat.div_done) state_d = C_R_REG;
			C_R_REG:     state_d = C_READ;
			C_READ:      state_d = C_RESULT;
			C_RESULT:    if (emit) state_d = C_IDLE;
			default:     state_d = C_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = DP_NOP;
		cmd.k  = k_q;
		case (state_q)
			C_SWEEP:    cmd.op = DP_SWEEP;
			C_IDLE:     if (item_valid) cmd.op = DP_CAPTURE;
			C_LOAD_DIV: cmd.op = DP_DIV_LOAD;
			C_EDGE_MUL: cmd.op = DP_EDGE_MUL;
			C_EDGE_SUB: cmd.op = DP_EDGE_SUB;
			C_W_DIV:    cmd.op = DP_DIV_WEIGHT;
			C_W_REG:    cmd.op = DP_WEIGHT;
			C_W_MUL:    cmd.op = DP_WEIGHT_MUL;
			C_W_ACC:    cmd.op = DP_ACC;
			C_R_DIV:    cmd.op = DP_DIV_RECIP;
			C_R_REG:    cmd.op = DP_DEPTH;
			C_READ:     cmd.op = DP_READ;
			C_RESULT:   if (emit) cmd.op = DP_EMIT;
			default:    cmd.op = DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_SWEEP;
			k_q         <= K_AREA;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				C_DECODE:   k_q <= K_AREA;
				C_EDGE_SUB: k_q <= k_q + 2'd1;
				C_AREA_CHK: k_q <= K_FIRST;
				C_W_ACC:    k_q <= k_q + 2'd1;
				default: ;
			endcase
			if (emit)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign item_ready   = (state_q == C_IDLE);
	assign result_valid = out_valid_q;

	`TDT_ASSERT_NEXT(a_accept_decodes, item_valid && item_ready, state_q == C_DECODE, "transfer not decoded")
	`TDT_ASSERT_NEXT(a_free_slot_emits, state_q == C_RESULT && !out_valid_q, state_q == C_IDLE && out_valid_q, "result not emitted")
	`TDT_ASSERT_NOW(a_weight_not_area, state_q == C_W_DIV || state_q == C_W_MUL, k_q != K_AREA, "weight on area edge")

endmodule

@@ rtl/core/triangle_depth_test.sv @@
`timescale 1ns / 1ps

// Perspective-correct depth test. One result per item. Loads and tests are dominated by a
// single shared restoring divider: one pass for a corner reciprocal, four for a test (three
// barycentric weights plus the final depth reciprocal). Clears, bad operations and
// out-of-range pixels do not use the divider. After reset the depth store is swept to far,
// one entry a cycle, over all MAX_WIDTH*MAX_HEIGHT entries (65536 by default); no item is
// taken until it ends.
module triangle_depth_test import tdt_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  in_item_t                  item,
	output logic                      result_valid,
	input  logic                      result_ready,
	output out_item_t                 result,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]       cfg_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	tdt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	tdt_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.DEPTH_BITS (DEPTH_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.item      (item),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

@@ verif/triangle_depth_checker.sv @@
`timescale 1ns / 1ps

module triangle_depth_checker import tdt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  logic                      item_ready,
	input  in_item_t                  item,
	input  logic                      result_valid,
	input  logic                      result_ready,
	input  out_item_t                 result,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]       cfg_data,
	output int                        fail_count,
	output int                        pending
);

	localparam logic [31:0] FAR_DEPTH = 32'hFFFF_FFFF;

	logic [CFG_BITS-1:0] width_reg, height_reg;
	logic [15:0]         vx [3];
	logic [15:0]         vy [3];
	logic [31:0]         vinv [3];
	logic [31:0]         zbuf [65536];
	out_item_t           expected_q [$];

	function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
			longint px, longint py);
		return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
	endfunction

	function automatic longint weight_fn(longint num, longint den);
		logic neg;
		longint unsigned un, ud, q;
		neg = (num < 0) != (den < 0);
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -den : den;
		q = ((un << 16) + ud / 2) / ud;
		if (q > WEIGHT_LIMIT)
			q = WEIGHT_LIMIT;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic out_item_t depth_predict(in_item_t it);
		out_item_t r;
		int unsigned w, h, idx;
		longint area, s, tx, ty;
		longint unsigned d, us, q;
		logic [31:0] dep;
		w = (width_reg > 256) ? 256 : width_reg;
		h = (height_reg > 256) ? 256 : height_reg;
		r.status = ST_DONE;
		r.depth_value = '0;
		if (it.operation == OP_LOAD) begin
			if (it.vertex_slot != SLOT_NONE) begin
				d = {32'h0, it.vertex_depth};
				vx[it.vertex_slot] = it.vertex_x;
				vy[it.vertex_slot] = it.vertex_y;
				if (d <= 1)
					vinv[it.vertex_slot] = INV_INFINITY;
				else
					vinv[it.vertex_slot] = 32'(((64'd1 << 32) + d / 2) / d);
			end
			return r;
		end
		if (it.operation != OP_TEST && it.operation != OP_CLEAR)
			return r;
		if (it.pixel_x >= w || it.pixel_y >= h) begin
			r.status = ST_OUTSIDE;
			return r;
		end
		idx = it.pixel_y * w + it.pixel_x;
		if (it.operation == OP_CLEAR) begin
			zbuf[idx] = FAR_DEPTH;
			return r;
		end
		tx = longint'({48'h0, it.pixel_x, 8'h0});
		ty = longint'({48'h0, it.pixel_y, 8'h0});
		area = edge_fn(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
		if (area == 0) begin
			r.status = ST_DEGEN;
			return r;
		end
		s = weight_fn(edge_fn(vx[1], vy[1], vx[2], vy[2], tx, ty), area)
				* longint'({32'h0, vinv[0]})
			+ weight_fn(edge_fn(vx[2], vy[2], vx[0], vy[0], tx, ty), area)
				* longint'({32'h0, vinv[1]})
			+ weight_fn(edge_fn(vx[0], vy[0], vx[1], vy[1], tx, ty), area)
				* longint'({32'h0, vinv[2]});
		if (s <= 0) begin
			dep = FAR_DEPTH;
		end else begin
			us = s;
			q = ((64'd1 << 48) + us / 2) / us;
			dep = (q > {32'h0, FAR_DEPTH}) ? FAR_DEPTH : q[31:0];
		end
		r.depth_value = dep;
		if (dep < zbuf[idx]) begin
			zbuf[idx] = dep;
			r.status = ST_PASS;
		end else begin
			r.status = ST_HIDDEN;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		if (!arst_n) begin
			width_reg  <= ACTIVE_RESET;
			height_reg <= ACTIVE_RESET;
			for (int i = 0; i < 3; i++) begin
				vx[i] = '0;
				vy[i] = '0;
				vinv[i] = '0;
			end
			for (int i = 0; i < 65536; i++)
				zbuf[i] = FAR_DEPTH;
			expected_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ACTIVE_WIDTH)
					width_reg <= cfg_data;
				else if (cfg_index == REG_ACTIVE_HEIGHT)
					height_reg <= cfg_data;
			end
			if (item_valid && item_ready)
				expected_q.push_back(depth_predict(item));
			if (result_valid && result_ready) begin
				if (expected_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result transfer: status %0d depth %h",
							result.status, result.depth_value);
				end else begin
					exp_r = expected_q.pop_front();
					if (result.status !== exp_r.status
							|| result.depth_value !== exp_r.depth_value) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: status exp %0d got %0d, depth exp %h got %h",
								exp_r.status, result.status, exp_r.depth_value,
								result.depth_value);
					end
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import tdt_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int ITEM_TARGET    = 1350;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      item_valid = 1'b0;
	logic                      item_ready;
	in_item_t                  item = '0;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	out_item_t                 result;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0]       cfg_data = '0;
	int                        fail_count, pending;
	int                        sent = 0;
	int                        stall_cnt = 0;
	bit                        quick = 1'b0;
	bit                        hold_req = 1'b0;

	triangle_depth_test u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	triangle_depth_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// result side: random back-pressure (none in quick mode), one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = quick ? 0 : $urandom_range(0, 12);
			if (hold_req) begin
				hold_req = 1'b0;
				n = 600;
			end
			if (n > 0) begin
				result_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	task automatic send(in_item_t it);
		int gap;
		gap = quick ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		sent++;
	endtask

	function automatic in_item_t mk(logic [1:0] op, logic [1:0] slot, logic [15:0] x,
			logic [15:0] y, logic [31:0] d, logic [7:0] px, logic [7:0] py);
		in_item_t it;
		it.operation = op;
		it.vertex_slot = slot;
		it.vertex_x = x;
		it.vertex_y = y;
		it.vertex_depth = d;
		it.pixel_x = px;
		it.pixel_y = py;
		return it;
	endfunction

	function automatic in_item_t noise_item();
		return mk(2'($urandom), 2'($urandom), 16'($urandom), 16'($urandom), $urandom,
			8'($urandom), 8'($urandom));
	endfunction

	function automatic logic [31:0] rand_depth();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 3);
			1: return $urandom_range(32'h100, 32'hFFFFF);
			2: return $urandom;
			3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom_range(32'h8000, 32'h800000);
		endcase
	endfunction

	function automatic in_item_t rand_corner(logic [1:0] slot, int win);
		in_item_t it;
		it = noise_item();
		it.operation = OP_LOAD;
		it.vertex_slot = slot;
		it.vertex_depth = rand_depth();
		if ($urandom_range(0, 4) != 0) begin
			it.vertex_x = {8'($urandom_range(0, win)), 8'($urandom)};
			it.vertex_y = {8'($urandom_range(0, win)), 8'($urandom)};
		end
		return it;
	endfunction

	task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		int widths [7];
		int heights [7];
		int win, lim, target;
		in_item_t it;

		widths  = '{256, 1, 511, 17, 256, 0, 100};
		heights = '{256, 1, 300, 200, 1, 256, 256};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		send(mk(OP_TEST, 0, 0, 0, 0, 5, 5));
		send(mk(OP_LOAD, 0, 16'h0000, 16'h0000, 32'h0001_0000, 0, 0));
		send(mk(OP_LOAD, 1, 16'hFF00, 16'h0000, 32'h0000_0001, 0, 0));
		send(mk(OP_LOAD, 2, 16'h0000, 16'hFF00, 32'hFFFF_FFFF, 0, 0));
		send(mk(OP_TEST, 0, 0, 0, 0, 0, 0));
		send(mk(OP_TEST, 0, 0, 0, 0, 255, 255));
		send(mk(OP_TEST, 0, 0, 0, 0, 128, 0));
		send(mk(OP_TEST, 0, 0, 0, 0, 0, 128));
		send(mk(OP_TEST, 0, 0, 0, 0, 0, 0));
		send(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
		send(mk(OP_TEST, 0, 0, 0, 0, 0, 0));
		send(mk(OP_LOAD, SLOT_NONE, 16'hFFFF, 16'hFFFF, 32'h5, 0, 0));
		send(mk(2'd3, 2'd3, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
		send(mk(OP_LOAD, 1, 16'hFFFF, 16'h0000, 32'h0000_0000, 0, 0));
		send(mk(OP_LOAD, 2, 16'hFFFF, 16'hFFFF, 32'h0002_0000, 0, 0));
		send(mk(OP_TEST, 0, 0, 0, 0, 10, 10));
		send(mk(OP_TEST, 0, 0, 0, 0, 255, 0));
		send(mk(OP_LOAD, 0, 16'h0100, 16'h0100, 32'h10000, 0, 0));
		send(mk(OP_LOAD, 1, 16'h0200, 16'h0200, 32'h20000, 0, 0));
		send(mk(OP_LOAD, 2, 16'h0300, 16'h0300, 32'h30000, 0, 0));
		send(mk(OP_TEST, 0, 0, 0, 0, 1, 1));
		send(mk(OP_CLEAR, 0, 0, 0, 0, 255, 255));
		drain();

		for (int p = 0; p < 7; p++) begin
			if (p > 0) begin
				cfg_write(REG_ACTIVE_WIDTH, CFG_BITS'(widths[p]));
				cfg_write(REG_ACTIVE_HEIGHT, CFG_BITS'(heights[p]));
			end
			quick = (p == 3);
			if (p == 2)
				hold_req = 1'b1;
			target = ITEM_TARGET * (p + 1) / 7;
			lim = (widths[p] > 256 ? 256 : widths[p]) + 2;
			if (lim > 255)
				lim = 255;
			while (sent < target) begin
				win = ($urandom_range(0, 3) == 0) ? 255 : 15;
				for (int k = 0; k < 3; k++)
					send(rand_corner(k, win));
				repeat ($urandom_range(2, 7)) begin
					case ($urandom_range(0, 9))
						0: send(noise_item());
						1: begin
							it = noise_item();
							it.operation = OP_CLEAR;
							it.pixel_x = $urandom_range(0, win < lim ? win : lim);
							it.pixel_y = $urandom_range(0, win < lim ? win : lim);
							send(it);
						end
						default: begin
							it = noise_item();
							it.operation = OP_TEST;
							if ($urandom_range(0, 7) != 0) begin
								it.pixel_x = $urandom_range(0, win < lim ? win : lim);
								it.pixel_y = $urandom_range(0, win < lim ? win : lim);
							end
							send(it);
						end
					endcase
				end
			end
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
